>>> hw/rtl/tfn_pkg.sv
// Shared constants and types for the triangle face normal block.
// Used by every module under hw/rtl; depends on nothing.
package tfn_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int QUO_BITS       = 31;
	localparam int ROOT_BITS      = 16;
	localparam int NORM_BITS      = 16;

	typedef logic signed [NORM_BITS-1:0] norm_t;

endpackage

>>> hw/rtl/tfn_cross.sv
// Edge vectors, cross product and sign/magnitude split, four register stages.
// Depends on tfn_pkg.
module tfn_cross #(
	parameter int CB = tfn_pkg::COORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              ce,
	input  logic [CB-1:0]     coord [9],
	output logic [2*CB+1:0]   mag_s4 [3],
	output logic              neg_s4 [3]
);

	localparam int DW = CB + 1;
	localparam int PW = 2 * DW;
	localparam int NW = PW + 1;

	logic signed [DW-1:0] u_s1 [3];
	logic signed [DW-1:0] w_s1 [3];
	logic signed [PW-1:0] p_s2 [6];
	logic signed [NW-1:0] n_s3 [3];

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				u_s1[i] <= DW'($signed(coord[3+i])) - DW'($signed(coord[i]));
				w_s1[i] <= DW'($signed(coord[6+i])) - DW'($signed(coord[i]));
			end
			p_s2[0] <= u_s1[1] * w_s1[2];
			p_s2[1] <= u_s1[2] * w_s1[1];
			p_s2[2] <= u_s1[2] * w_s1[0];
			p_s2[3] <= u_s1[0] * w_s1[2];
			p_s2[4] <= u_s1[0] * w_s1[1];
			p_s2[5] <= u_s1[1] * w_s1[0];
			for (int i = 0; i < 3; i++) begin
				n_s3[i]   <= NW'(p_s2[2*i]) - NW'(p_s2[2*i+1]);
				neg_s4[i] <= n_s3[i][NW-1];
				mag_s4[i] <= n_s3[i][NW-1] ? PW'(-n_s3[i]) : PW'(n_s3[i]);
			end
		end
	end

endmodule

>>> hw/rtl/tfn_len.sv
// Squares of the cross product components from split partial products, and
// the squared length, three register stages. Depends on tfn_pkg.
module tfn_len #(
	parameter int MB = 2 * tfn_pkg::COORD_BITS_DEF + 2
) (
	input  logic              clk,
	input  logic              ce,
	input  logic [MB-1:0]     mag [3],
	input  logic              neg [3],
	output logic [2*MB-1:0]   sq_s3 [3],
	output logic [2*MB+1:0]   len_s3,
	output logic              neg_s3 [3]
);

	localparam int H   = (MB + 1) / 2;
	localparam int HW  = MB - H;
	localparam int SQW = 2 * MB;
	localparam int SW  = SQW + 2;

	logic [2*HW-1:0]   hh_s1 [3];
	logic [HW+H-1:0]   hl_s1 [3];
	logic [2*H-1:0]    ll_s1 [3];
	logic              neg_s1 [3];
	logic [SQW-1:0]    sq_s2 [3];
	logic              neg_s2 [3];

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				hh_s1[i]  <= mag[i][MB-1:H] * mag[i][MB-1:H];
				hl_s1[i]  <= mag[i][MB-1:H] * mag[i][H-1:0];
				ll_s1[i]  <= mag[i][H-1:0] * mag[i][H-1:0];
				neg_s1[i] <= neg[i];
				sq_s2[i]  <= (SQW'(hh_s1[i]) << (2 * H)) + (SQW'(hl_s1[i]) << (H + 1))
					+ SQW'(ll_s1[i]);
				neg_s2[i] <= neg_s1[i];
				sq_s3[i]  <= sq_s2[i];
				neg_s3[i] <= neg_s2[i];
			end
			len_s3 <= SW'(sq_s2[0]) + SW'(sq_s2[1]) + SW'(sq_s2[2]);
		end
	end

endmodule

>>> hw/rtl/tfn_div.sv
// Pipelined restoring divider, one quotient bit per stage: floor(num * 2^(QW-1) / den)
// for num <= den. Depends on tfn_pkg.
module tfn_div #(
	parameter int NUMW = 4 * tfn_pkg::COORD_BITS_DEF + 4,
	parameter int DENW = 4 * tfn_pkg::COORD_BITS_DEF + 6,
	parameter int QW   = tfn_pkg::QUO_BITS
) (
	input  logic             clk,
	input  logic             ce,
	input  logic [NUMW-1:0]  num,
	input  logic [DENW-1:0]  den,
	input  logic             neg,
	output logic [QW-1:0]    quo,
	output logic             neg_out
);

	localparam int TW = DENW + 1;

	logic [DENW-1:0] r_s   [QW];
	logic [DENW-1:0] den_s [QW];
	logic [QW-1:0]   q_s   [QW];
	logic            neg_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [TW-1:0]   trial;
		logic [DENW-1:0] den_in;
		logic [QW-1:0]   q_in;
		logic            neg_in;
		logic            take;

		if (k == 0) begin : g_first
			assign trial  = TW'(num);
			assign den_in = den;
			assign q_in   = '0;
			assign neg_in = neg;
		end else begin : g_next
			assign trial  = {r_s[k-1], 1'b0};
			assign den_in = den_s[k-1];
			assign q_in   = q_s[k-1];
			assign neg_in = neg_s[k-1];
		end

		assign take = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (ce) begin
				r_s[k]   <= take ? DENW'(trial - {1'b0, den_in}) : DENW'(trial);
				den_s[k] <= den_in;
				q_s[k]   <= {q_in[QW-2:0], take};
				neg_s[k] <= neg_in;
			end
		end
	end

	assign quo     = q_s[QW-1];
	assign neg_out = neg_s[QW-1];

endmodule

>>> hw/rtl/tfn_sqrt.sv
// Pipelined integer square root, one root bit per stage, then rounding to
// Q1.14 and sign. Depends on tfn_pkg.
module tfn_sqrt #(
	parameter int QW  = tfn_pkg::QUO_BITS,
	parameter int RTW = tfn_pkg::ROOT_BITS
) (
	input  logic                 clk,
	input  logic                 ce,
	input  logic [QW-1:0]        f,
	input  logic                 neg,
	output tfn_pkg::norm_t       norm_q
);

	localparam int NB = tfn_pkg::NORM_BITS;

	logic [RTW-1:0] root_s [RTW];
	logic [QW-1:0]  f_s    [RTW];
	logic           neg_s  [RTW];

	for (genvar k = 0; k < RTW; k++) begin : g_stage
		logic [RTW-1:0]   root_in;
		logic [QW-1:0]    f_in;
		logic             neg_in;
		logic [RTW-1:0]   t;
		logic [2*RTW-1:0] t2;

		if (k == 0) begin : g_first
			assign root_in = '0;
			assign f_in    = f;
			assign neg_in  = neg;
		end else begin : g_next
			assign root_in = root_s[k-1];
			assign f_in    = f_s[k-1];
			assign neg_in  = neg_s[k-1];
		end

		assign t  = root_in | (RTW'(1) << (RTW - 1 - k));
		assign t2 = t * t;

		always_ff @(posedge clk) begin
			if (ce) begin
				root_s[k] <= (t2 <= (2 * RTW)'(f_in)) ? t : root_in;
				f_s[k]    <= f_in;
				neg_s[k]  <= neg_in;
			end
		end
	end

	logic [RTW:0]   rnd;
	logic [RTW-1:0] mag;

	always_comb begin
		rnd = {1'b0, root_s[RTW-1]} + (RTW+1)'(1);
		mag = rnd[RTW:1];
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			norm_q <= (neg_s[RTW-1] && mag != '0) ? -NB'(mag) : NB'(mag);
		end
	end

endmodule

>>> hw/rtl/triangle_face_normal_top.sv
// Top level of the triangle face normal block.
// Depends on tfn_pkg, tfn_cross, tfn_len, tfn_div and tfn_sqrt.
//
// One request on the input stream carries one triangle: nine signed
// coordinates a_x..c_z, COORD_BITS each, packed from the lowest bit up.
// One request on the output stream carries its unit normal: norm_x, norm_y
// and norm_z in signed Q1.14 in tdata, and the degenerate flag in tuser.
// A degenerate triangle gives a zero vector with the flag set.
// The pipeline has four stages for the cross product, three for squares
// and length, one per quotient bit in the divider and one per root bit in
// the square root, plus the rounding stage.
// Throughput is one triangle per cycle while the receiver does not stall.
// Reset clears all valid bits; the pipeline is empty afterwards.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops; nothing is lost or repeated.
module triangle_face_normal_top #(
	parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from the lowest bit up.
	input  logic [((9*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// norm_x, norm_y, norm_z from the lowest bit up.
	output logic [3*tfn_pkg::NORM_BITS-1:0]        m_axis_tdata,
	// degenerate.
	output logic                                   m_axis_tuser
);

	localparam int MB  = 2 * COORD_BITS + 2;
	localparam int SQW = 2 * MB;
	localparam int SW  = SQW + 2;
	localparam int QW  = tfn_pkg::QUO_BITS;
	localparam int RTW = tfn_pkg::ROOT_BITS;
	localparam int DGL = QW + RTW + 1;
	localparam int LAT = 7 + DGL;

	logic                    ce;
	logic [COORD_BITS-1:0]   coord [9];
	logic [MB-1:0]           mag [3];
	logic                    neg [3];
	logic [SQW-1:0]          sq [3];
	logic [SW-1:0]           len2;
	logic                    lneg [3];
	logic [QW-1:0]           quo [3];
	logic                    dneg [3];
	tfn_pkg::norm_t          norm [3];
	logic                    vld_q [LAT];
	logic                    dg_q [DGL];

	assign ce            = !vld_q[LAT-1] || m_axis_tready;
	assign s_axis_tready = ce;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			coord[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
		end
	end

	tfn_cross #(.CB(COORD_BITS)) u_cross (
		.clk(clk), .ce(ce), .coord(coord), .mag_s4(mag), .neg_s4(neg)
	);

	tfn_len #(.MB(MB)) u_len (
		.clk(clk), .ce(ce), .mag(mag), .neg(neg),
		.sq_s3(sq), .len_s3(len2), .neg_s3(lneg)
	);

	for (genvar c = 0; c < 3; c++) begin : g_comp
		tfn_div #(.NUMW(SQW), .DENW(SW), .QW(QW)) u_div (
			.clk(clk), .ce(ce), .num(sq[c]), .den(len2), .neg(lneg[c]),
			.quo(quo[c]), .neg_out(dneg[c])
		);
		tfn_sqrt #(.QW(QW), .RTW(RTW)) u_sqrt (
			.clk(clk), .ce(ce), .f(quo[c]), .neg(dneg[c]), .norm_q(norm[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (ce) begin
			vld_q[0] <= s_axis_tvalid;
			for (int k = 1; k < LAT; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			dg_q[0] <= (len2 == '0);
			for (int k = 1; k < DGL; k++) begin
				dg_q[k] <= dg_q[k-1];
			end
		end
	end

	assign m_axis_tvalid = vld_q[LAT-1];
	assign m_axis_tuser  = dg_q[DGL-1];
	assign m_axis_tdata  = dg_q[DGL-1] ? '0 : {norm[2], norm[1], norm[0]};

endmodule

>>> hw/rtl/tfn_chk.sv
// Port-level checks for the triangle face normal block, bound to the top level.
// Depends on tfn_pkg and triangle_face_normal_top.
module tfn_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [3*tfn_pkg::NORM_BITS-1:0]   m_axis_tdata,
	input logic                              m_axis_tuser
);

	localparam int NB = tfn_pkg::NORM_BITS;

	logic signed [NB-1:0] nx;
	logic signed [NB-1:0] ny;
	logic signed [NB-1:0] nz;

	assign nx = m_axis_tdata[NB-1:0];
	assign ny = m_axis_tdata[2*NB-1:NB];
	assign nz = m_axis_tdata[3*NB-1:2*NB];

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("degenerate result carries a nonzero normal");

	a_normal_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata != '0)
		else $error("regular triangle gave a zero normal");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> nx <= 16384 && nx >= -16384 && ny <= 16384 && ny >= -16384
			&& nz <= 16384 && nz >= -16384)
		else $error("normal component beyond plus or minus one");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while no result waits");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind triangle_face_normal_top tfn_chk u_tfn_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);
